### rtl/heq_pkg.sv
package heq_pkg;

   localparam int MAX_PIXELS = 1048576;
   localparam int PIX_W      = 8;
   localparam int BINS       = 1 << PIX_W;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int ACC_W      = CNT_W + 9;

   localparam logic REQ_COUNT = 1'b0;
   localparam logic REQ_MAP   = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] mapped_pixel;
      logic             table_valid;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_SETTLE,
      ST_READ,
      ST_ACC,
      ST_MUL,
      ST_STEP
   } heq_state_type;

   typedef struct packed {
      logic busy;
      logic clr_we;
      logic walk_rd;
   } heq_ctrl_type;

endpackage

### rtl/histogram_equalizer_8bit_unit.sv
// Map transaction: result passes through the s1 stage and the output register; count and map
// transactions are accepted one per cycle while not busy and not held by a stalled map response.
// Frame end: table build sequencer walks 256 bins through ST_READ, ST_ACC, ST_MUL and ST_STEP, with
// an extra ST_STEP pass per output level step (at most 255), input stalled throughout.
// Reset (synchronous): a clear pass over all 256 bins zeroes the bin memory, input stalled.
module histogram_equalizer_8bit_unit
   import heq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic [CNT_W-1:0] bin_mem [BINS];
   logic [PIX_W-1:0] tbl_mem [BINS];

   heq_state_type state_ff, state_in;
   heq_ctrl_type  ctrl;

   logic [PIX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] cum_ff, cum_in;
   logic [ACC_W-1:0] num_ff, num_in;
   logic [ACC_W-1:0] prod_ff, prod_in;
   logic [PIX_W-1:0] q_ff, q_in;
   logic             built_ff, built_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_map_ff;
   logic             s1_cnt_ff;
   logic [PIX_W-1:0] s1_pix_ff;

   logic             fwd_valid_ff;
   logic [PIX_W-1:0] fwd_addr_ff;
   logic [CNT_W-1:0] fwd_data_ff;

   logic [CNT_W-1:0] bin_rd_ff;
   logic [PIX_W-1:0] tbl_rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff;

   logic             s1_hold, accept, acc_count, acc_map, counted;
   logic             fend_acc, step_go, last_bin, out_load;
   logic             bin_we, bin_re, tbl_we;
   logic [PIX_W-1:0] bin_wa, bin_ra;
   logic [CNT_W-1:0] bin_wd, s1_bin;

   // handshake
   assign s1_hold   = s1_valid_ff & s1_map_ff & rsp_valid_ff & rsp_stall;
   assign req_stall = ctrl.busy | s1_hold;
   assign accept    = req_valid & ~req_stall;
   assign acc_count = accept & (req_data.req_type == REQ_COUNT);
   assign acc_map   = accept & (req_data.req_type == REQ_MAP);
   assign counted   = total_ff < CNT_W'(MAX_PIXELS);
   assign fend_acc  = acc_count & req_data.frame_end;

   // build sequencer helpers
   assign step_go  = (total_ff != '0) && (num_ff >= prod_ff);
   assign last_bin = idx_ff == PIX_W'(BINS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (last_bin) state_in = ST_RUN;
         ST_RUN:    if (fend_acc) state_in = ST_SETTLE;
         ST_SETTLE: state_in = ST_READ;
         ST_READ:   state_in = ST_ACC;
         ST_ACC:    state_in = ST_MUL;
         ST_MUL:    state_in = ST_STEP;
         ST_STEP: begin
            if (!step_go) state_in = last_bin ? ST_RUN : ST_READ;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.busy   = 1'b1;
            ctrl.clr_we = 1'b1;
         end
         ST_RUN: ctrl = '0;
         ST_READ: begin
            ctrl.busy    = 1'b1;
            ctrl.clr_we  = 1'b1;
            ctrl.walk_rd = 1'b1;
         end
         ST_SETTLE, ST_ACC, ST_MUL, ST_STEP: ctrl.busy = 1'b1;
         default: ctrl.busy = 1'b1;
      endcase
   end

   // sequencer datapath
   always_comb begin
      idx_in   = idx_ff;
      total_in = total_ff;
      cum_in   = cum_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      built_in = built_ff;
      if (acc_count && counted) total_in = total_ff + CNT_W'(1);
      unique case (state_ff)
         ST_CLEAR: idx_in = idx_ff + PIX_W'(1);
         ST_SETTLE: begin
            idx_in  = '0;
            cum_in  = '0;
            q_in    = '0;
            prod_in = ACC_W'({total_ff, 1'b0});
         end
         ST_ACC: cum_in = cum_ff + bin_rd_ff;
         ST_MUL: num_in = {cum_ff, 9'b0} - ACC_W'({cum_ff, 1'b0}) + ACC_W'(total_ff);
         ST_STEP: begin
            if (step_go) begin
               q_in    = q_ff + PIX_W'(1);
               prod_in = prod_ff + ACC_W'({total_ff, 1'b0});
            end else if (last_bin) begin
               cum_in   = '0;
               total_in = '0;
               built_in = 1'b1;
            end else begin
               idx_in = idx_ff + PIX_W'(1);
            end
         end
         ST_RUN, ST_READ: idx_in = idx_ff;
         default: idx_in = idx_ff;
      endcase
   end

   // bin memory ports
   assign s1_bin = (fwd_valid_ff && fwd_addr_ff == s1_pix_ff) ? fwd_data_ff : bin_rd_ff;

   always_comb begin
      bin_we = 1'b0;
      bin_wa = idx_ff;
      bin_wd = '0;
      if (ctrl.clr_we) begin
         bin_we = 1'b1;
      end else if (s1_valid_ff && !s1_map_ff && s1_cnt_ff) begin
         bin_we = 1'b1;
         bin_wa = s1_pix_ff;
         bin_wd = s1_bin + CNT_W'(1);
      end
   end

   assign bin_re = acc_count | ctrl.walk_rd;
   assign bin_ra = ctrl.walk_rd ? idx_ff : req_data.pixel;
   assign tbl_we = (state_ff == ST_STEP) & ~step_go;

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_wa] <= bin_wd;
      if (bin_re) bin_rd_ff <= bin_mem[bin_ra];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[idx_ff] <= q_ff;
      if (acc_map) tbl_rd_ff <= tbl_mem[req_data.pixel];
   end

   // pipeline stage and output register
   assign s1_valid_in  = s1_hold ? s1_valid_ff : accept;
   assign out_load     = s1_valid_ff & s1_map_ff & ~(rsp_valid_ff & rsp_stall);
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (!s1_hold) begin
         s1_map_ff <= req_data.req_type == REQ_MAP;
         s1_cnt_ff <= counted;
         s1_pix_ff <= req_data.pixel;
      end
      fwd_addr_ff <= bin_wa;
      fwd_data_ff <= bin_wd;
      if (out_load) begin
         rsp_data_ff.mapped_pixel <= built_ff ? tbl_rd_ff : s1_pix_ff;
         rsp_data_ff.table_valid  <= built_ff;
      end
      cum_ff  <= cum_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         total_ff     <= '0;
         built_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         built_ff     <= built_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= bin_we;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/heq_checker.sv
module heq_checker
   import heq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_table_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_valid |=> !rsp_valid || rsp_data.table_valid)
      else $error("table_valid dropped after build");

   a_build_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type == REQ_COUNT && req_data.frame_end
      |=> req_stall)
      else $error("frame end transaction did not start table build");

   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall && !rsp_valid)
      else $error("input taken during bin clear");

endmodule

bind histogram_equalizer_8bit_unit heq_checker u_heq_checker (.*);
